@@ hdl/mrx_pkg.sv @@
// Package for the mixed-radix expression evaluator.
// Holds character codes, command encodings, the command struct and small helper functions.
// Used by every module of the block; depends on nothing.
package mrx_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int MEM_DEPTH  = 64;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int CNT_W      = $clog2(MEM_DEPTH + 1);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [1:0] OP_PLUS  = 2'd0;
    localparam logic [1:0] OP_MINUS = 2'd1;
    localparam logic [1:0] OP_TIMES = 2'd2;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_DIGIT  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [7:0] DEC_BASE = 8'd10;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] digit;
        logic [7:0] base;
        logic [1:0] op;
        logic       last;
        logic       emit;
        logic [5:0] out_base;
        logic       too_long;
    } t_cmd;

    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [5:0] v;
        v = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 6'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            v = 6'(c - CH_LA + 8'd10);
        end
        return v;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] r;
        if (d < 6'd10) begin
            r = CH_ZERO + {2'b00, d};
        end else begin
            r = CH_LA + {2'b00, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

@@ hdl/mrx_if.sv @@
// Handshake channel interfaces of the mixed-radix expression evaluator.
// One interface for the character input and one for the result digits.
// Depends on nothing.
interface mrx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;
    modport source (output valid, char_in, end_of_text, input ready);
    modport sink (input valid, char_in, end_of_text, output ready);
endinterface

interface mrx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_char;
    logic       is_negative;
    logic [5:0] out_base;
    logic       too_long;
    logic       last_digit;
    modport source (output valid, digit_char, is_negative, out_base, too_long, last_digit,
                    input ready);
    modport sink (input valid, digit_char, is_negative, out_base, too_long, last_digit,
                  output ready);
endinterface

@@ hdl/mrx_front.sv @@
// Front end: accepts characters, tracks the parse phase and bases, and issues commands.
// Depends on mrx_pkg and mrx_in_if.
module mrx_front import mrx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mrx_in_if.sink   i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [1:0] PH_DIGITS   = 2'd0;
    localparam logic [1:0] PH_BASE     = 2'd1;
    localparam logic [1:0] PH_AFTER_EQ = 2'd2;
    localparam logic [1:0] PH_RES_BASE = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_radix, n_radix;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             accept, is_op;
    logic [7:0]       c;
    t_cmd             cmd;

    function automatic logic [7:0] add_dec(input logic [7:0] acc, input logic [5:0] v);
        logic [11:0] s;
        s = 12'(acc) * 12'd10 + 12'(v);
        return (s > 12'd255) ? 8'd255 : s[7:0];
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign c          = i_in.char_in;
    assign is_op      = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_TIMES) || (c == CH_EQ);

    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        cmd     = '0;
        unique case (r_phase) inside
            PH_DIGITS, PH_BASE: begin
                if (is_op) begin
                    cmd.kind = CMD_FINISH;
                    cmd.base = (r_phase == PH_BASE) ? r_radix : DEC_BASE;
                    cmd.op   = (c == CH_TIMES) ? OP_TIMES : (c == CH_MINUS) ? OP_MINUS : OP_PLUS;
                    n_cnt    = '0;
                    n_radix  = '0;
                    n_phase  = (c == CH_EQ) ? PH_AFTER_EQ : PH_DIGITS;
                end else if (c == CH_CARET) begin
                    if (r_phase == PH_DIGITS) begin
                        n_phase = PH_BASE;
                        n_radix = '0;
                    end
                end else if (r_phase == PH_DIGITS) begin
                    if (r_cnt < CNT_W'(MAX_DIGITS)) begin
                        cmd.kind  = CMD_DIGIT;
                        cmd.digit = char_value(c);
                        n_cnt     = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    n_radix = add_dec(r_radix, char_value(c));
                end
            end
            PH_AFTER_EQ: begin
                if (c == CH_CARET) begin
                    n_phase = PH_RES_BASE;
                    n_radix = '0;
                end
            end
            default: begin
                if (!is_op && c != CH_CARET) begin
                    n_radix = add_dec(r_radix, char_value(c));
                end
            end
        endcase
        if (i_in.end_of_text) begin
            cmd.last     = 1'b1;
            cmd.emit     = (n_phase == PH_RES_BASE);
            cmd.out_base = (n_radix < 8'd2) ? 6'd2 : (n_radix > 8'd36) ? 6'd36 : n_radix[5:0];
            cmd.too_long = n_ovf;
            n_phase      = PH_DIGITS;
            n_radix      = '0;
            n_cnt        = '0;
            n_ovf        = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.kind != CMD_NONE || cmd.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DIGITS;
            r_radix <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

endmodule

@@ hdl/mrx_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on mrx_pkg.
module mrx_cmd_fifo import mrx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + FIFO_CW'(i_push) - FIFO_CW'(i_pop);
        end
    end

endmodule

@@ hdl/mrx_back.sv @@
// Back end: stores operand digits, converts and combines operands, and writes the result digits.
// Holds the digit memory, the sum and product registers and the bit-serial divider.
// Depends on mrx_pkg and mrx_out_if.
module mrx_back import mrx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_cmd     i_cmd,
    output logic     o_pop,
    mrx_out_if.source o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_APPLY = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_STORE = 4'd6;
    localparam logic [3:0] S_ORD   = 4'd7;
    localparam logic [3:0] S_OLD   = 4'd8;

    logic [3:0]        r_state;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_wptr, r_idx, r_ndig;
    logic [63:0]       r_acc, r_term, r_sum, r_prod, r_mag;
    logic [1:0]        r_mcnt, r_op;
    logic [5:0]        r_rem, r_bcnt;
    logic              r_neg;
    logic [5:0]        r_mem [MEM_DEPTH];
    logic [5:0]        r_rd;
    logic              r_ovalid, r_oneg, r_otl, r_olast;
    logic [7:0]        r_odig;
    logic [5:0]        r_obase;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa, mem_ra;
    logic [5:0]        mem_wd;
    logic [15:0]       chunk;
    logic [63:0]       pp, term;
    logic [6:0]        rem_sh;
    logic              ge, out_free, out_load;
    logic [CNT_W-1:0]  ndig_inc;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign chunk    = r_acc[{r_mcnt, 4'b0000} +: 16];
    assign pp       = (r_prod * {48'b0, chunk}) << {r_mcnt, 4'b0000};
    assign term     = (r_op == OP_TIMES) ? r_term : (r_op == OP_MINUS) ? (64'd0 - r_acc) : r_acc;
    assign rem_sh   = {r_rem, r_mag[63]};
    assign ge       = (rem_sh >= {1'b0, r_cmd.out_base});
    assign out_free = !r_ovalid || o_out.ready;
    assign out_load = (r_state == S_OLD) && out_free;
    assign ndig_inc = r_ndig + 1'b1;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wptr[MEM_AW-1:0];
        mem_wd = i_cmd.digit;
        mem_ra = MEM_AW'(r_ndig - 1'b1);
        if (r_state == S_IDLE) begin
            mem_we = o_pop && (i_cmd.kind == CMD_DIGIT);
        end else if (r_state == S_STORE) begin
            mem_we = 1'b1;
            mem_wa = r_ndig[MEM_AW-1:0];
            mem_wd = r_rem;
        end
        if (r_state == S_RD) begin
            mem_ra = r_idx[MEM_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= '0;
            r_wptr   <= '0;
            r_idx    <= '0;
            r_ndig   <= '0;
            r_acc    <= '0;
            r_term   <= '0;
            r_sum    <= '0;
            r_prod   <= '0;
            r_mag    <= '0;
            r_mcnt   <= '0;
            r_op     <= OP_PLUS;
            r_rem    <= '0;
            r_bcnt   <= '0;
            r_neg    <= 1'b0;
            r_ovalid <= 1'b0;
            r_oneg   <= 1'b0;
            r_otl    <= 1'b0;
            r_olast  <= 1'b0;
            r_odig   <= '0;
            r_obase  <= '0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.kind == CMD_FINISH) begin
                            r_idx   <= '0;
                            r_acc   <= '0;
                            r_state <= S_RD;
                        end else if (i_cmd.last && i_cmd.emit) begin
                            r_neg   <= r_sum[63];
                            r_mag   <= r_sum[63] ? (64'd0 - r_sum) : r_sum;
                            r_ndig  <= '0;
                            r_rem   <= '0;
                            r_bcnt  <= '0;
                            r_state <= S_DIV;
                        end else if (i_cmd.last) begin
                            r_sum  <= '0;
                            r_prod <= '0;
                            r_op   <= OP_PLUS;
                            r_wptr <= '0;
                        end else if (i_cmd.kind == CMD_DIGIT) begin
                            r_wptr <= r_wptr + 1'b1;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx == r_wptr) begin
                        r_term  <= '0;
                        r_mcnt  <= '0;
                        r_state <= (r_op == OP_TIMES) ? S_MUL : S_APPLY;
                    end else begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= r_acc * {56'b0, r_cmd.base} + {58'b0, r_rd};
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_RD;
                end
                S_MUL: begin
                    r_term <= r_term + pp;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 2'd3) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_wptr  <= '0;
                    r_state <= S_IDLE;
                    if (r_cmd.last) begin
                        r_sum  <= '0;
                        r_prod <= '0;
                        r_op   <= OP_PLUS;
                    end else if (r_cmd.op == OP_TIMES) begin
                        r_prod <= term;
                        r_op   <= OP_TIMES;
                    end else begin
                        r_sum  <= r_sum + term;
                        r_prod <= '0;
                        r_op   <= r_cmd.op;
                    end
                end
                S_DIV: begin
                    r_mag  <= {r_mag[62:0], ge};
                    r_rem  <= ge ? 6'(rem_sh - {1'b0, r_cmd.out_base}) : rem_sh[5:0];
                    r_bcnt <= r_bcnt + 1'b1;
                    if (r_bcnt == 6'd63) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_ndig <= ndig_inc;
                    if (r_mag != '0 && ndig_inc < CNT_W'(MEM_DEPTH)) begin
                        r_rem   <= '0;
                        r_bcnt  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_ORD;
                    end
                end
                S_ORD: begin
                    r_state <= S_OLD;
                end
                S_OLD: begin
                    if (out_free) begin
                        r_odig   <= digit_char(r_rd);
                        r_oneg   <= r_neg;
                        r_obase  <= r_cmd.out_base;
                        r_otl    <= r_cmd.too_long;
                        r_olast  <= (r_ndig == CNT_W'(1));
                        r_ndig   <= r_ndig - 1'b1;
                        if (r_ndig == CNT_W'(1)) begin
                            r_sum   <= '0;
                            r_prod  <= '0;
                            r_op    <= OP_PLUS;
                            r_wptr  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.digit_char  = r_odig;
    assign o_out.is_negative = r_oneg;
    assign o_out.out_base    = r_obase;
    assign o_out.too_long    = r_otl;
    assign o_out.last_digit  = r_olast;

`ifndef ASSERT_OFF
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_cmd.out_base))
        else $error("Divider remainder is not below the result base.");

    a_wptr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= CNT_W'(MAX_DIGITS))
        else $error("Operand digit count exceeds the digit store.");

    a_digit_in_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLD) |-> (r_rd < r_cmd.out_base))
        else $error("Stored result digit is not below the result base.");

    a_idle_no_output_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OLD))
        else $error("Result beat raised outside the output load state.");
`endif

endmodule

@@ hdl/mixed_radix_expression_evaluator.sv @@
// Top level of the mixed-radix expression evaluator.
// Connects the front end, the command queue and the back end; depends on mrx_pkg and mrx_if.
//
// Usage: the input channel carries one ASCII character per beat, with end_of_text set on the
// final character of an expression. The output channel carries one result digit per beat,
// most significant first, with the sign, result base and overflow flag repeated in every beat
// and last_digit set on the final one. Texts without a result base give no beats.
// A character that only updates parse state pushes no command and leaves the back end
// alone. A stored operand digit is written to the digit memory as the back end pops it.
// Each operator reads and accumulates every stored digit of the operand in the conversion
// loop, multiplies by the held product when it follows a '*', and applies the term. The
// radix division is bit-serial, and the digit memory is then read out in reverse order.
// The two-entry command queue lets characters be taken while the back end is busy.
// Reset clears all parse state and arithmetic registers; the digit memory needs no clearing.
// When the receiver stalls, the output register holds its beat and the back end waits,
// and once the queue fills the input channel deasserts ready.
module mixed_radix_expression_evaluator import mrx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrx_in_if.sink    i_in,
    mrx_out_if.source o_out
);

    logic push, pop, full, empty;
    t_cmd cmd_in, cmd_out;

    mrx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    mrx_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    mrx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (cmd_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
